// ===== src/assert_macros.svh =====
// Assertion macros shared by the solver RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== src/slss_pkg.sv =====
// Shared constants for the small linear system solver.
// No dependencies; used by the top level and the divider.
`timescale 1ns / 1ps
package slss_pkg;
	localparam int ACC_W  = 64;
	localparam int PROD_W = 48;
	localparam int SOL_W  = 48;
	localparam int FRAC_W = 16;
	localparam int PERM_CNT = 24;

	// Column picked for rows 0..3 by each permutation of four, packed {r3,r2,r1,r0}
	localparam logic [7:0] PERM_TBL [PERM_CNT] = '{
		{2'd3, 2'd2, 2'd1, 2'd0}, {2'd2, 2'd3, 2'd1, 2'd0}, {2'd3, 2'd1, 2'd2, 2'd0},
		{2'd1, 2'd3, 2'd2, 2'd0}, {2'd2, 2'd1, 2'd3, 2'd0}, {2'd1, 2'd2, 2'd3, 2'd0},
		{2'd3, 2'd2, 2'd0, 2'd1}, {2'd2, 2'd3, 2'd0, 2'd1}, {2'd3, 2'd0, 2'd2, 2'd1},
		{2'd0, 2'd3, 2'd2, 2'd1}, {2'd2, 2'd0, 2'd3, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
		{2'd3, 2'd1, 2'd0, 2'd2}, {2'd1, 2'd3, 2'd0, 2'd2}, {2'd3, 2'd0, 2'd1, 2'd2},
		{2'd0, 2'd3, 2'd1, 2'd2}, {2'd1, 2'd0, 2'd3, 2'd2}, {2'd0, 2'd1, 2'd3, 2'd2},
		{2'd2, 2'd1, 2'd0, 2'd3}, {2'd1, 2'd2, 2'd0, 2'd3}, {2'd2, 2'd0, 2'd1, 2'd3},
		{2'd0, 2'd2, 2'd1, 2'd3}, {2'd1, 2'd0, 2'd2, 2'd3}, {2'd0, 2'd1, 2'd2, 2'd3}
	};

	// Odd permutations contribute with a minus sign
	localparam logic PERM_ODD [PERM_CNT] = '{
		1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
		1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
		1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
		1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0
	};

	function automatic logic [1:0] perm_col(input logic [4:0] p, input logic [1:0] r);
		logic [7:0] w;
		w = PERM_TBL[p];
		return w[2*r +: 2];
	endfunction
endpackage

// ===== src/slss_div.sv =====
// Bit-serial signed divider: quot = num * 2^16 / den, truncated, saturated to 48 bits.
// Depends on slss_pkg.
`timescale 1ns / 1ps
module slss_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [slss_pkg::ACC_W-1:0] num,
	input  logic signed [slss_pkg::ACC_W-1:0] den,
	output logic                              done,
	output logic [slss_pkg::SOL_W-1:0]        quot
);
	localparam int DVD_W = slss_pkg::ACC_W + slss_pkg::FRAC_W;
	localparam int Q_W   = slss_pkg::SOL_W - 1;

	logic                           run_q;
	logic                           fin_q;
	logic                           done_q;
	logic [6:0]                     cnt_q;
	logic                           neg_q;
	logic                           ovf_q;
	logic [slss_pkg::ACC_W-1:0]     den_q;
	logic [slss_pkg::ACC_W-1:0]     rem_q;
	logic [DVD_W-1:0]               dvd_q;
	logic [Q_W-1:0]                 q_q;
	logic [slss_pkg::SOL_W-1:0]     quot_q;
	logic [slss_pkg::ACC_W:0]       rem_sh;
	logic [slss_pkg::ACC_W:0]       rem_sub;
	logic                           ge;
	logic [slss_pkg::ACC_W-1:0]     num_abs;
	logic [slss_pkg::ACC_W-1:0]     den_abs;
	logic [slss_pkg::SOL_W-1:0]     mag;

	// Magnitudes of the operands
	assign num_abs = num[slss_pkg::ACC_W-1] ? slss_pkg::ACC_W'(-num) : num;
	assign den_abs = den[slss_pkg::ACC_W-1] ? slss_pkg::ACC_W'(-den) : den;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = rem_sh >= {1'b0, den_q};

	// Saturate when any quotient bit above the 47-bit range was set
	assign mag = ovf_q ? (neg_q ? {1'b1, {Q_W{1'b0}}} : {1'b0, {Q_W{1'b1}}})
	                   : {1'b0, q_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 7'(DVD_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd0) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[slss_pkg::ACC_W-1] ^ den[slss_pkg::ACC_W-1];
			den_q <= den_abs;
			dvd_q <= {num_abs, {slss_pkg::FRAC_W{1'b0}}};
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (run_q) begin
			rem_q <= ge ? rem_sub[slss_pkg::ACC_W-1:0] : rem_sh[slss_pkg::ACC_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			q_q   <= {q_q[Q_W-2:0], ge};
			ovf_q <= ovf_q | q_q[Q_W-1];
		end
		if (fin_q) begin
			quot_q <= neg_q ? slss_pkg::SOL_W'(-mag) : mag;
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

// ===== src/small_linear_system_solver_top.sv =====
// Flow: n*n+n load beats, one per cycle while start is high and busy is low, then the determinant
// terms of n+1 determinants, a drain, and the serial divider once per unknown (one result each).
// Results leave as one-cycle strobes; the receiver cannot stall them.
// arst_n clears control, the load position and sets the order to four; stores stay unset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module small_linear_system_solver_top #(
	parameter int N_MAX     = 4,
	parameter int ELEM_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [11:0]                value,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [2:0]                        cfg_data,
	output logic                              result_strobe,
	output logic signed [slss_pkg::SOL_W-1:0] solution,
	output logic [1:0]                        index,
	output logic                              singular,
	output logic                              last
);
	localparam int RW     = (N_MAX > 1) ? $clog2(N_MAX) : 1;
	localparam int MDEPTH = N_MAX * N_MAX;
	localparam int AW     = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;

	typedef enum logic [3:0] {
		S_LOAD  = 4'b0001,
		S_DET   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DIV   = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [2:0]                     size_q;
	logic [2:0]                     n_use;
	logic [2:0]                     nm1;
	logic                           accept;
	logic signed [ELEM_BITS-1:0]    elem;

	logic [RW-1:0]                  ld_row_q;
	logic [RW-1:0]                  ld_col_q;
	logic                           ld_rhs_q;
	logic                           ld_row_last;
	logic                           ld_col_last;

	logic signed [ELEM_BITS-1:0]    mat_mem [MDEPTH];
	logic signed [ELEM_BITS-1:0]    rhs_mem [N_MAX];
	logic signed [ELEM_BITS-1:0]    mat_rd_q;
	logic signed [ELEM_BITS-1:0]    rhs_rd_q;
	logic [AW-1:0]                  waddr;
	logic [AW-1:0]                  raddr;

	logic [2:0]                     seq_det_q;
	logic [4:0]                     seq_perm_q;
	logic [1:0]                     seq_row_q;
	logic [1:0]                     col;

	logic                           v_s1;
	logic                           real_s1;
	logic                           rhs_s1;
	logic                           first_row_s1;
	logic                           last_row_s1;
	logic                           first_perm_s1;
	logic                           end_s1;
	logic                           neg_s1;
	logic                           ok_s1;
	logic [2:0]                     det_s1;

	logic signed [slss_pkg::PROD_W-1:0] prod_s2;
	logic signed [ELEM_BITS-1:0]    fac;
	logic                           tv_s2;
	logic                           tfirst_s2;
	logic                           tend_s2;
	logic                           tneg_s2;
	logic                           tok_s2;
	logic [2:0]                     tdet_s2;

	logic signed [slss_pkg::ACC_W-1:0] acc_q;
	logic signed [slss_pkg::ACC_W-1:0] term;
	logic signed [slss_pkg::ACC_W-1:0] sum;
	logic signed [slss_pkg::ACC_W-1:0] det_q;
	logic signed [slss_pkg::ACC_W-1:0] num_q [N_MAX];
	logic [2:0]                     num_sel;

	logic [RW-1:0]                  k_q;
	logic                           wait_q;
	logic                           div_start;
	logic                           div_done;
	logic [slss_pkg::SOL_W-1:0]     div_quot;

	logic                           strobe_q;
	logic [slss_pkg::SOL_W-1:0]     sol_q;
	logic [1:0]                     idx_q;
	logic                           sing_q;
	logic                           last_q;

	// Permutation keeps rows at or beyond the order on their own column
	function automatic logic perm_fits(input logic [4:0] p, input logic [2:0] n);
		logic ok;
		ok = 1'b1;
		for (int r = 0; r < 4; r++) begin
			if (3'(r) >= n && slss_pkg::perm_col(p, 2'(r)) != 2'(r)) ok = 1'b0;
		end
		return ok;
	endfunction

	// Order in use, clamped to 1..N_MAX
	assign n_use = (size_q == 3'd0) ? 3'd1 : ((size_q > 3'(N_MAX)) ? 3'(N_MAX) : size_q);
	assign nm1   = n_use - 3'd1;

	assign busy      = (state_q != S_LOAD);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign elem      = value[ELEM_BITS-1:0];

	assign ld_row_last = (3'(ld_row_q) == nm1);
	assign ld_col_last = (3'(ld_col_q) == nm1);
	assign waddr = AW'(int'(ld_row_q) * N_MAX + int'(ld_col_q));

	assign col   = slss_pkg::perm_col(seq_perm_q, seq_row_q);
	assign raddr = AW'(int'(seq_row_q) * N_MAX + int'(col));

	// Store the incoming beats
	always_ff @(posedge clk) begin
		if (accept && !ld_rhs_q) mat_mem[waddr] <= elem;
		if (accept && ld_rhs_q) rhs_mem[ld_row_q] <= elem;
	end

	// Read one matrix entry and one right-hand side entry per cycle
	always_ff @(posedge clk) begin
		mat_rd_q <= mat_mem[raddr];
		rhs_rd_q <= rhs_mem[seq_row_q[RW-1:0]];
	end

	// Configuration register and load position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= 3'd4;
			ld_row_q <= '0;
			ld_col_q <= '0;
			ld_rhs_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			size_q   <= cfg_data;
			ld_row_q <= '0;
			ld_col_q <= '0;
			ld_rhs_q <= 1'b0;
		end else if (accept) begin
			if (ld_rhs_q) begin
				ld_row_q <= ld_row_last ? '0 : ld_row_q + 1'b1;
				if (ld_row_last) ld_rhs_q <= 1'b0;
			end else if (ld_col_last) begin
				ld_col_q <= '0;
				ld_row_q <= ld_row_last ? '0 : ld_row_q + 1'b1;
				if (ld_row_last) ld_rhs_q <= 1'b1;
			end else begin
				ld_col_q <= ld_col_q + 1'b1;
			end
		end
	end

	// Sequencer: walk determinants, permutations and rows; drain, then divide or flag a singular system
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			seq_det_q  <= '0;
			seq_perm_q <= '0;
			seq_row_q  <= '0;
			k_q        <= '0;
			wait_q     <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					if (accept && ld_rhs_q && ld_row_last) begin
						state_q    <= S_DET;
						seq_det_q  <= '0;
						seq_perm_q <= '0;
						seq_row_q  <= '0;
					end
				end
				S_DET: begin
					seq_row_q <= seq_row_q + 2'd1;
					if (seq_row_q == 2'd3) begin
						if (seq_perm_q == 5'(slss_pkg::PERM_CNT - 1)) begin
							seq_perm_q <= '0;
							seq_det_q  <= seq_det_q + 3'd1;
							if (seq_det_q == n_use) state_q <= S_DRAIN;
						end else begin
							seq_perm_q <= seq_perm_q + 5'd1;
						end
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !tv_s2) begin
						k_q    <= '0;
						wait_q <= 1'b0;
						if (det_q == '0) begin
							state_q  <= S_LOAD;
							strobe_q <= 1'b1;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (div_done) begin
						wait_q   <= 1'b0;
						strobe_q <= 1'b1;
						k_q      <= k_q + 1'b1;
						if (3'(k_q) == nm1) state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == S_DRAIN) begin
			sol_q  <= '0;
			idx_q  <= '0;
			sing_q <= 1'b1;
			last_q <= 1'b1;
		end else if (state_q == S_DIV && wait_q && div_done) begin
			sol_q  <= div_quot;
			idx_q  <= 2'(k_q);
			sing_q <= 1'b0;
			last_q <= (3'(k_q) == nm1);
		end
	end

	// Stage 1: read issued, hold term control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_DET);
		end
	end

	always_ff @(posedge clk) begin
		real_s1       <= 3'(seq_row_q) < n_use;
		rhs_s1        <= (seq_det_q != 3'd0) && ({1'b0, col} == 3'(seq_det_q - 3'd1));
		first_row_s1  <= (seq_row_q == 2'd0);
		last_row_s1   <= (seq_row_q == 2'd3);
		first_perm_s1 <= (seq_perm_q == 5'd0);
		end_s1        <= (seq_perm_q == 5'(slss_pkg::PERM_CNT - 1)) && (seq_row_q == 2'd3);
		neg_s1        <= slss_pkg::PERM_ODD[seq_perm_q];
		ok_s1         <= perm_fits(seq_perm_q, n_use);
		det_s1        <= seq_det_q;
	end

	// Stage 2: multiply the running product by this row's factor
	assign fac = !real_s1 ? ELEM_BITS'(1) : (rhs_s1 ? rhs_rd_q : mat_rd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv_s2 <= 1'b0;
		end else begin
			tv_s2 <= v_s1 && last_row_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= first_row_s1 ? slss_pkg::PROD_W'(fac)
			                        : slss_pkg::PROD_W'(prod_s2 * fac);
		end
		tfirst_s2 <= first_perm_s1;
		tend_s2   <= end_s1;
		tneg_s2   <= neg_s1;
		tok_s2    <= ok_s1;
		tdet_s2   <= det_s1;
	end

	// Stage 3: accumulate signed terms, file finished determinants
	assign term    = slss_pkg::ACC_W'(prod_s2);
	assign sum     = (tfirst_s2 ? '0 : acc_q) + (tok_s2 ? (tneg_s2 ? -term : term) : '0);
	assign num_sel = tdet_s2 - 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_q <= '0;
		end else if (tv_s2 && tend_s2 && tdet_s2 == 3'd0) begin
			det_q <= sum;
		end
	end

	always_ff @(posedge clk) begin
		if (tv_s2) acc_q <= sum;
		if (tv_s2 && tend_s2 && tdet_s2 != 3'd0) num_q[num_sel[RW-1:0]] <= sum;
	end

	// Divider for the Q32.16 quotients
	assign div_start = (state_q == S_DIV) && !wait_q;

	slss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q[k_q]),
		.den    (det_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign result_strobe = strobe_q;
	assign solution      = sol_q;
	assign index         = idx_q;
	assign singular      = sing_q;
	assign last          = last_q;

	`ASSERT_PROP(a_last_idle, clk, arst_n, (result_strobe && last) |-> !busy)
	`ASSERT_PROP(a_mid_busy, clk, arst_n, (result_strobe && !last) |-> busy)
	`ASSERT_PROP(a_sing_one, clk, arst_n, (result_strobe && singular) |-> (last && index == 2'd0))
	`ASSERT_PROP(a_busy_cause, clk, arst_n, $rose(busy) |-> $past(start))
	`ASSERT_NEVER(a_no_div_out, clk, arst_n, div_done && state_q != S_DIV)
endmodule

// ===== sim/tb_small_linear_system_solver_top.sv =====
// Testbench for small_linear_system_solver_top: loads integer systems beat by beat,
// predicts the Q32.16 solutions with a behavioral solver and checks each result strobe.
// Depends on the solver RTL and slss_pkg.
`timescale 1ns / 1ps
module tb_small_linear_system_solver_top;

	localparam int LIMIT_CYCLES = 2000000;

	typedef struct {
		logic signed [slss_pkg::SOL_W-1:0] solution;
		logic [1:0] index;
		logic singular;
		logic last;
	} sol_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [11:0] value = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_data = '0;
	logic result_strobe;
	logic signed [slss_pkg::SOL_W-1:0] solution;
	logic [1:0] index;
	logic singular;
	logic last;

	// predictor state
	longint mat [4][4];
	longint rhs [4];
	int fill_pos;
	int order_reg;
	sol_t pending_sols [$];
	int errors = 0;
	int cycles = 0;
	bit no_idle = 0;

	small_linear_system_solver_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .value(value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_strobe(result_strobe), .solution(solution), .index(index),
		.singular(singular), .last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_small_linear_system_solver_top: done, errors");
			$finish;
		end
	end

	function automatic int eff_order();
		if (order_reg < 1) return 1;
		if (order_reg > 4) return 4;
		return order_reg;
	endfunction

	// determinant by cofactor expansion along the first row of the leading k x k block
	function automatic longint leading_det(longint m [4][4], int k);
		longint sub [4][4];
		longint acc;
		int sj;
		acc = 0;
		if (k == 1) return m[0][0];
		for (int x = 0; x < k; x++) begin
			for (int i = 1; i < k; i++) begin
				sj = 0;
				for (int j = 0; j < k; j++)
					if (j != x) begin
						sub[i-1][sj] = m[i][j];
						sj++;
					end
			end
			if (x % 2) acc -= m[0][x] * leading_det(sub, k - 1);
			else acc += m[0][x] * leading_det(sub, k - 1);
		end
		return acc;
	endfunction

	// num * 2^16 / den toward zero, saturated to 48 bits
	function automatic logic [slss_pkg::SOL_W-1:0] q16_quotient(longint num, longint den);
		bit neg;
		logic [63:0] un, ud, q, r, mag, lim;
		neg = (num < 0) != (den < 0);
		un = num < 0 ? -num : num;
		ud = den < 0 ? -den : den;
		q = un / ud;
		r = un % ud;
		lim = neg ? (64'd1 << 47) : ((64'd1 << 47) - 1);
		if (q >= (64'd1 << 31)) mag = lim;
		else begin
			mag = q << 16;
			for (int b = 15; b >= 0; b--) begin
				r = r << 1;
				if (r >= ud) begin
					r -= ud;
					mag[b] = 1'b1;
				end
			end
			if (mag > lim) mag = lim;
		end
		if (neg) mag = -mag;
		return mag[slss_pkg::SOL_W-1:0];
	endfunction

	// absorb one entry; queue expected solutions when the system is complete
	task automatic predict_entry(logic signed [11:0] v);
		int n;
		longint a [4][4];
		longint c [4][4];
		longint det, num;
		sol_t s;
		n = eff_order();
		if (fill_pos < n * n) mat[fill_pos / n][fill_pos % n] = longint'(v);
		else rhs[fill_pos - n * n] = longint'(v);
		fill_pos++;
		if (fill_pos < n * n + n) return;
		fill_pos = 0;
		a = mat;
		det = leading_det(a, n);
		if (det == 0) begin
			s.solution = '0; s.index = '0; s.singular = 1'b1; s.last = 1'b1;
			pending_sols.push_back(s);
			return;
		end
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++)
					c[i][j] = (j == k) ? rhs[i] : a[i][j];
			num = leading_det(c, n);
			s.solution = q16_quotient(num, det);
			s.index = 2'(k);
			s.singular = 1'b0;
			s.last = (k == n - 1);
			pending_sols.push_back(s);
		end
	endtask

	// check each result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (pending_sols.size() == 0) begin
				$display("%0t: unexpected result sol=%0d idx=%0d", $time, solution, index);
				errors++;
			end else begin
				sol_t e;
				e = pending_sols.pop_front();
				if (solution !== e.solution || index !== e.index ||
				    singular !== e.singular || last !== e.last) begin
					$display("%0t: mismatch exp sol=%0d idx=%0d sing=%0b last=%0b",
						$time, e.solution, e.index, e.singular, e.last);
					$display("%0t:          got sol=%0d idx=%0d sing=%0b last=%0b",
						$time, solution, index, singular, last);
					errors++;
				end
			end
		end
	end

	// offer one beat; start stays high after it until an idle cycle or drain drops it
	task automatic send_entry(logic signed [11:0] v);
		if (!no_idle)
			while ($urandom_range(99) < 32) begin
				start <= 1'b0;
				@(posedge clk);
			end
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_entry(v);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_sols.size() != 0) @(posedge clk);
		repeat (900) @(posedge clk);
	endtask

	task automatic write_order(logic [2:0] d);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		order_reg = int'(d);
		fill_pos = 0;
	endtask

	function automatic logic signed [11:0] rand_entry();
		case ($urandom_range(5))
			0: return 12'sh7ff;
			1: return 12'sh800;
			2: return 12'($urandom_range(7) - 3);
			default: return 12'($urandom);
		endcase
	endfunction

	task automatic send_system(int n, bit make_singular);
		logic signed [11:0] row0 [4];
		for (int i = 0; i < n * n; i++) begin
			logic signed [11:0] v;
			v = rand_entry();
			if (i < n) row0[i] = v;
			if (make_singular && n > 1 && i >= n && i < 2 * n) v = row0[i - n];
			send_entry(v);
		end
		for (int i = 0; i < n; i++) send_entry(rand_entry());
	endtask

	// extremes, singular systems, orders 1, 2 and 4, and the clamped orders 0 and 7
	task automatic test_directed();
		write_order(3'd1);
		send_entry(12'sh7ff); send_entry(12'sh800);
		send_entry(12'sh001); send_entry(12'sh7ff);
		send_entry(12'sh000); send_entry(12'sh123);
		write_order(3'd2);
		send_entry(12'sd1); send_entry(12'sd2); send_entry(12'sd2); send_entry(12'sd4);
		send_entry(12'sd5); send_entry(-12'sd6);
		write_order(3'd0);
		send_entry(-12'sd1); send_entry(12'sh800);
		write_order(3'd7);
		send_system(4, 0);
	endtask

	// restart loading mid-system by rewriting the order
	task automatic test_mid_load_restart();
		write_order(3'd3);
		send_entry(12'sd5); send_entry(-12'sd7);
		write_order(3'd3);
		send_system(3, 0);
	endtask

	task automatic test_random();
		int sent;
		int n;
		sent = 0;
		while (sent < 110) begin
			n = $urandom_range(4, 1);
			if ($urandom_range(3) == 0) write_order(3'(n));
			n = eff_order();
			no_idle = (sent > 30 && sent < 70);
			send_system(n, $urandom_range(7) == 0);
			sent += n * n + n;
		end
		no_idle = 0;
		write_order(3'd4);
		send_system(4, 0);
	endtask

	initial begin
		order_reg = 4;
		fill_pos = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_mid_load_restart();
		test_random();
		drain();
		if (errors == 0) $display("tb_small_linear_system_solver_top: done, clean");
		else $display("tb_small_linear_system_solver_top: done, errors");
		$finish;
	end
endmodule
